// ===== rtl/core/sida_pkg.sv =====
package sida_pkg;

  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CHAR_W   = 6;
  localparam int unsigned CONST_W  = 68;
  localparam int unsigned MAX_POS  = 20;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic               neg;
    logic               pos_zero;
    logic [DIGIT_W-1:0] digit;
  } status_t;

  // Number of decimal positions needed for the largest magnitude 2^(w-1).
  function automatic int unsigned dec_digits(int unsigned w);
    logic [CONST_W-1:0] lim;
    logic [CONST_W-1:0] p;
    int unsigned        n;
    lim = CONST_W'(1) << (w - 1);
    p   = CONST_W'(1);
    n   = 1;
    for (int i = 0; i < MAX_POS; i++) begin
      if (p * CONST_W'(10) <= lim) begin
        p = p * CONST_W'(10);
        n = n + 1;
      end
    end
    return n;
  endfunction

  // k * 10^p, evaluated at elaboration only.
  function automatic logic [CONST_W-1:0] pow10_mult(int unsigned p, int unsigned k);
    logic [CONST_W-1:0] r;
    r = CONST_W'(k);
    for (int i = 0; i < MAX_POS; i++) begin
      if (i < p) begin
        r = r * CONST_W'(10);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sida_dp.sv =====
module sida_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  sida_pkg::cmd_t                cmd,
  output sida_pkg::status_t             status
);

  localparam int unsigned NUM_DIGITS = sida_pkg::dec_digits(VALUE_WIDTH);
  localparam int unsigned POS_W      = $clog2(NUM_DIGITS);
  localparam int unsigned MW         = VALUE_WIDTH + 4;

  logic [VALUE_WIDTH-1:0] rem;
  logic [POS_W-1:0]       pos;
  logic                   neg;

  // Multiples 1..9 of each power of ten, a constant table.
  logic [MW-1:0] mult_tbl [NUM_DIGITS][9];

  for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_pow
    for (genvar k = 1; k < 10; k++) begin : g_mul
      localparam logic [sida_pkg::CONST_W-1:0] M = sida_pkg::pow10_mult(p, k);
      assign mult_tbl[p][k-1] = M[MW-1:0];
    end
  end

  logic [MW:0]                  diff [9];
  logic [sida_pkg::DIGIT_W-1:0] digit;
  logic [VALUE_WIDTH-1:0]       rem_next;

  // All nine trial subtractions run side by side; the largest one that
  // does not go negative gives the digit and the new remainder.
  always_comb begin
    digit    = '0;
    rem_next = rem;
    for (int k = 0; k < 9; k++) begin
      diff[k] = {5'b0, rem} - {1'b0, mult_tbl[pos][k]};
    end
    for (int k = 0; k < 9; k++) begin
      if (!diff[k][MW]) begin
        digit    = sida_pkg::DIGIT_W'(k + 1);
        rem_next = diff[k][VALUE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_WIDTH-1];
      // The most negative value keeps its full magnitude as unsigned.
      rem <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      pos <= POS_W'(NUM_DIGITS - 1);
    end else if (cmd.step) begin
      rem <= rem_next;
      if (pos != '0) begin
        pos <= pos - 1'b1;
      end
    end
  end

  assign status.neg      = neg;
  assign status.pos_zero = (pos == '0);
  assign status.digit    = digit;

endmodule

// ===== rtl/core/sida_ctrl.sv =====
module sida_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  sida_pkg::status_t                   status,
  output sida_pkg::cmd_t                      cmd,
  output logic                                char_valid,
  output logic [sida_pkg::CHAR_W-1:0]         ascii_char,
  output logic                                last_char
);

  typedef enum logic [1:0] {
    IDLE,
    SIGN,
    DIGIT
  } state_t;

  state_t state;
  logic   started;
  logic   emit;

  assign busy     = (state != IDLE);
  assign cmd.load = (state == IDLE) && start;
  assign cmd.step = (state == DIGIT);

  // Leading zeros are dropped, but the units position always prints.
  assign emit = started || (status.digit != '0) || status.pos_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      started    <= 1'b0;
      char_valid <= 1'b0;
      last_char  <= 1'b0;
      ascii_char <= '0;
    end else begin
      char_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            started <= 1'b0;
            state   <= SIGN;
          end
        end
        SIGN: begin
          if (status.neg) begin
            char_valid <= 1'b1;
            ascii_char <= sida_pkg::CHAR_MINUS;
            last_char  <= 1'b0;
          end
          state <= DIGIT;
        end
        DIGIT: begin
          if (emit) begin
            char_valid <= 1'b1;
            ascii_char <= sida_pkg::CHAR_ZERO + {2'b00, status.digit};
            last_char  <= status.pos_zero;
            started    <= 1'b1;
          end
          if (status.pos_zero) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII converter.
//
// An item is taken at a rising edge where start is high and busy is low; value
// is a two's complement integer of VALUE_WIDTH bits. The block then emits the
// decimal text one character per strobe: char_valid is high for exactly one
// cycle with ascii_char (45 for '-', 48 to 57 for digits) and last_char, which
// marks the final character. Digits come most significant first without
// leading zeros; zero prints as a single '0'.
//
// The controller passes through a SIGN state and then one DIGIT state per
// decimal position of the widest magnitude (10 at the default width); busy
// stays high throughout, so the next item is taken only once the previous one
// is complete. A minus sign is registered out of the SIGN state and the first
// digit out of a DIGIT state after it, and the last digit is presented in the
// first cycle with busy low again. Each position is resolved by nine parallel
// trial subtractions of power-of-ten multiples.
//
// The receiver cannot stall the output; characters are simply presented. A
// synchronous reset returns the controller to idle and drops any character in
// progress.
module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          char_valid,
  output logic [5:0]                    ascii_char,
  output logic                          last_char
);

  sida_pkg::cmd_t    cmd;
  sida_pkg::status_t status;

  sida_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk    (clk),
    .value  (value),
    .cmd    (cmd),
    .status (status)
  );

  sida_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .status     (status),
    .cmd        (cmd),
    .char_valid (char_valid),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule
